>>> rtl/slab_intensity_projection_top_defines.svh
// ----------------------------------------------------------------------------
// Slab intensity projection - assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SLAB_INTENSITY_PROJECTION_TOP_DEFINES_SVH
`define SLAB_INTENSITY_PROJECTION_TOP_DEFINES_SVH

// same-cycle implication
`define SIPJ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SIPJ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sipj_pkg.sv
// ----------------------------------------------------------------------------
// Slab intensity projection - package
// Sizes, mode codes and the structs shared by controller, datapath and top.
// ----------------------------------------------------------------------------
package sipj_pkg;

  localparam int MAX_SLICES = 256;
  localparam int SAMPLE_W   = 8;
  localparam int AW         = $clog2(MAX_SLICES);
  localparam int CW         = $clog2(MAX_SLICES + 1);
  localparam int SUM_W      = $clog2(MAX_SLICES * 255 + 1);
  localparam int DCW        = $clog2(SUM_W);
  localparam int SEARCH_STEPS = SAMPLE_W;
  localparam int ITW        = $clog2(SEARCH_STEPS);

  typedef enum logic [1:0] {
    MODE_MAX    = 2'd0,
    MODE_MIN    = 2'd1,
    MODE_MEAN   = 2'd2,
    MODE_MEDIAN = 2'd3
  } mode_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } in_req_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] projected;
    logic                overflow;
  } out_res_t;

  typedef struct packed {
    logic acc_en;        // sample request taken
    logic acc_last;      // ...and it ends the position
    logic out_direct;    // load output from max/min at end of position
    logic sel_min;
    logic div_step;
    logic rd_en;         // median sweep read
    logic med_update;
    logic out_from_res;  // load output from the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic last_addr;
    logic med_final;
  } dp_status_t;

endpackage

>>> rtl/sipj_ram.sv
// ----------------------------------------------------------------------------
// Slab intensity projection - generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sipj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/sipj_datapath.sv
// ----------------------------------------------------------------------------
// Slab intensity projection - datapath
// Accumulators, sample buffer, serial divider, median value search and
// the output register.
// ----------------------------------------------------------------------------
`include "slab_intensity_projection_top_defines.svh"

module sipj_datapath
  import sipj_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_req_t    in_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output out_res_t   out_data
);

  // running accumulators
  logic [SAMPLE_W-1:0] max_r, max_nxt;
  logic [SAMPLE_W-1:0] min_r, min_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                drop_r, drop_nxt;
  logic                room;

  // divider
  logic [SUM_W-1:0] quo_r;
  logic [CW-1:0]    rem_r, dvs_r;
  logic [DCW-1:0]   div_cnt_r;
  logic [CW:0]      trial;
  logic             trial_ge;
  logic [CW-1:0]    rem_nxt;
  logic [SUM_W-1:0] quo_nxt;

  // median search
  logic [CW-1:0]       n_r;
  logic [AW-1:0]       k_r;
  logic [SAMPLE_W-1:0] lo_r, hi_r, first_r;
  logic [ITW-1:0]      iter_r;
  logic                pass_r;
  logic [AW-1:0]       addr_r;
  logic [CW-1:0]       cnt_le_r;
  logic                rd_valid_r;
  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] mid;
  logic                go_lo;
  logic [SAMPLE_W-1:0] new_lo, new_hi;
  logic                even, iter_end, restart;
  logic [SAMPLE_W:0]   med_pair;
  logic [SAMPLE_W-1:0] med_val;

  logic [SAMPLE_W-1:0] res_r;
  logic                fin_drop_r;
  out_res_t            out_r;

  assign room = (count_r != CW'(MAX_SLICES));

  always_comb begin
    max_nxt   = max_r;
    min_nxt   = min_r;
    sum_nxt   = sum_r;
    count_nxt = count_r;
    drop_nxt  = drop_r;
    if (cmd.acc_en) begin
      if (room) begin
        if (in_data.sample > max_r) max_nxt = in_data.sample;
        if (in_data.sample < min_r) min_nxt = in_data.sample;
        sum_nxt   = sum_r + SUM_W'(in_data.sample);
        count_nxt = count_r + CW'(1);
      end else begin
        drop_nxt = 1'b1;
      end
    end
  end

  // restoring division, one quotient bit per step
  assign trial    = {rem_r, quo_r[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, dvs_r});
  assign rem_nxt  = trial_ge ? CW'(trial - {1'b0, dvs_r}) : CW'(trial);
  assign quo_nxt  = {quo_r[SUM_W-2:0], trial_ge};

  // binary search over sample values: smallest v with count(<= v) > k
  assign mid      = SAMPLE_W'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  assign go_lo    = (cnt_le_r > CW'(k_r));
  assign new_lo   = go_lo ? lo_r : mid + SAMPLE_W'(1);
  assign new_hi   = go_lo ? mid : hi_r;
  assign even     = ~n_r[0];
  assign iter_end = (iter_r == ITW'(SEARCH_STEPS - 1));
  assign restart  = iter_end & even & ~pass_r;
  assign med_pair = {1'b0, first_r} + {1'b0, new_lo};
  assign med_val  = even ? med_pair[SAMPLE_W:1] : new_lo;

  assign status.div_last  = (div_cnt_r == DCW'(SUM_W - 1));
  assign status.last_addr = (addr_r == AW'(n_r - CW'(1)));
  assign status.med_final = iter_end & ~restart;

  sipj_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_SLICES)
  ) u_buf (
    .clk  (clk),
    .we   (cmd.acc_en & room),
    .waddr(count_r[AW-1:0]),
    .wdata(in_data.sample),
    .re   (cmd.rd_en),
    .raddr(addr_r),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r      <= '0;
      min_r      <= '1;
      sum_r      <= '0;
      count_r    <= '0;
      drop_r     <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.rd_en;
      if (cmd.acc_last) begin
        max_r   <= '0;
        min_r   <= '1;
        sum_r   <= '0;
        count_r <= '0;
        drop_r  <= 1'b0;
      end else if (cmd.acc_en) begin
        max_r   <= max_nxt;
        min_r   <= min_nxt;
        sum_r   <= sum_nxt;
        count_r <= count_nxt;
        drop_r  <= drop_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_last) begin
      quo_r      <= sum_nxt;
      rem_r      <= '0;
      dvs_r      <= count_nxt;
      div_cnt_r  <= '0;
      n_r        <= count_nxt;
      k_r        <= AW'((count_nxt - CW'(1)) >> 1);
      lo_r       <= '0;
      hi_r       <= '1;
      iter_r     <= '0;
      pass_r     <= 1'b0;
      addr_r     <= '0;
      cnt_le_r   <= '0;
      fin_drop_r <= drop_nxt;
    end else begin
      if (cmd.div_step) begin
        quo_r     <= quo_nxt;
        rem_r     <= rem_nxt;
        div_cnt_r <= div_cnt_r + DCW'(1);
        if (status.div_last) res_r <= quo_nxt[SAMPLE_W-1:0];
      end
      if (cmd.rd_en) addr_r <= addr_r + AW'(1);
      if (cmd.med_update) begin
        addr_r   <= '0;
        cnt_le_r <= '0;
        if (restart) begin
          first_r <= new_lo;
          pass_r  <= 1'b1;
          k_r     <= k_r + AW'(1);
          lo_r    <= '0;
          hi_r    <= '1;
          iter_r  <= '0;
        end else begin
          lo_r   <= new_lo;
          hi_r   <= new_hi;
          iter_r <= iter_r + ITW'(1);
          if (iter_end) res_r <= med_val;
        end
      end else if (rd_valid_r && (rd_data <= mid)) begin
        cnt_le_r <= cnt_le_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_direct) begin
      out_r.projected <= cmd.sel_min ? min_nxt : max_nxt;
      out_r.overflow  <= drop_nxt;
    end else if (cmd.out_from_res) begin
      out_r.projected <= res_r;
      out_r.overflow  <= fin_drop_r;
    end
  end

  assign out_data = out_r;

  `SIPJ_ASSERT_IMP(a_sweep_in_range, cmd.rd_en, CW'(addr_r) < n_r,
    "median sweep read beyond the samples of this position")
  `SIPJ_ASSERT_IMP(a_search_converged, cmd.med_update && iter_end && !restart,
    new_lo == new_hi, "median value search did not converge")
  `SIPJ_ASSERT_IMP(a_quotient_fits, cmd.div_step && status.div_last,
    quo_nxt[SUM_W-1:SAMPLE_W] == '0, "mean quotient exceeds sample range")

endmodule

>>> rtl/sipj_ctrl.sv
// ----------------------------------------------------------------------------
// Slab intensity projection - controller
// Sequences accumulation, mean division, median search and result hand-off;
// holds the mode register and the output valid flag.
// ----------------------------------------------------------------------------
`include "slab_intensity_projection_top_defines.svh"

module sipj_ctrl
  import sipj_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_ACC,
    S_DIV,
    S_SWEEP,
    S_DRAIN,
    S_UPDATE,
    S_WAIT
  } state_t;

  state_t state_r, state_nxt;
  mode_t  mode_r;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, out_load, out_free;

  assign out_free = ~out_valid_r | ~out_stall;
  assign in_stall = (state_r != S_ACC) | ~out_free;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.acc_en   = accept;
    cmd.acc_last = accept & in_last;
    cmd.sel_min  = (mode_r == MODE_MIN);
    unique case (state_r)
      S_ACC: begin
        if (accept && in_last) begin
          unique case (mode_r)
            MODE_MAX, MODE_MIN: cmd.out_direct = 1'b1;
            MODE_MEAN:          state_nxt = S_DIV;
            MODE_MEDIAN:        state_nxt = S_SWEEP;
            default:            state_nxt = S_ACC;
          endcase
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_nxt = S_WAIT;
      end
      S_SWEEP: begin
        cmd.rd_en = 1'b1;
        if (status.last_addr) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_UPDATE;
      S_UPDATE: begin
        cmd.med_update = 1'b1;
        state_nxt = status.med_final ? S_WAIT : S_SWEEP;
      end
      S_WAIT: begin
        if (out_free) begin
          cmd.out_from_res = 1'b1;
          state_nxt = S_ACC;
        end
      end
      default: state_nxt = S_ACC;
    endcase
  end

  assign out_load      = cmd.out_direct | cmd.out_from_res;
  assign out_valid_nxt = out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      mode_r      <= MODE_MAX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) mode_r <= mode_t'(cfg_wdata);
    end
  end

  assign out_valid = out_valid_r;

  `SIPJ_ASSERT_NXT(a_busy_after_end,
    accept && in_last && (mode_r == MODE_MEAN || mode_r == MODE_MEDIAN),
    in_stall, "input taken while a mean or median is pending")
  `SIPJ_ASSERT_NXT(a_wait_delivers, state_r == S_WAIT && out_free,
    out_valid && state_r == S_ACC, "finished result not moved to output")
  `SIPJ_ASSERT_IMP(a_no_overwrite, out_load, out_free,
    "output register overwritten while its request is stalled")

endmodule

>>> rtl/slab_intensity_projection_top.sv
// ----------------------------------------------------------------------------
// Slab intensity projection - top level
// Projects one position through a slab: max, min, mean or median.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one sample request per accepted cycle (in_valid & !in_stall),
//           slices in order, in_data.last on the final slice of a position.
//   out_* : one request per position, {projected, overflow}, held while
//           out_stall is high.
//   cfg_* : cfg_we writes the 2-bit projection mode; write only when idle.
// Throughput: one sample per cycle while a position streams in, limited by
//   the sample buffer write port. The end of a position adds:
//     max/min : result registered at the edge the last sample is taken.
//     mean    : 16 divider steps, then a hand-off (serial divider).
//     median  : one search step per sample bit in each pass, then a hand-off,
//               two passes for even N; each step sweeps the buffer read port.
//   Input stalls during mean/median work and when the output is full and
//   stalled. Samples beyond 256 per position are dropped, overflow set.
// Reset: rst_n (synchronous) clears accumulators, mode (maximum) and the
//   output valid; the sample buffer needs no clearing.
// ----------------------------------------------------------------------------
module slab_intensity_projection_top
  import sipj_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  in_req_t    in_data,
  output logic       in_stall,
  output logic       out_valid,
  output out_res_t   out_data,
  input  logic       out_stall,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sipj_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .status   (status),
    .cmd      (cmd)
  );

  sipj_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .status  (status),
    .out_data(out_data)
  );

endmodule

>>> tb/slab_intensity_projection_top_tb.sv
// ----------------------------------------------------------------------------
// Slab intensity projection - testbench
// Streams slice requests for many positions under every projection mode,
// predicts each projected value and overflow flag, and checks every result
// request in order. Both sides idle at random; one long output hold-off backs
// the block up into its input.
// ----------------------------------------------------------------------------
module slab_intensity_projection_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sipj_pkg::*;

  localparam int IDLE_PCT       = 26;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_CYCLES    = 400;
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_BUDGET   = 60;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  in_req_t    in_data   = '0;
  logic       in_stall;
  logic       out_valid;
  out_res_t   out_data;
  logic       out_stall = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_wdata = 2'b00;

  // predictor state for the position being streamed
  mode_t       proj_mode   = MODE_MAX;
  logic [7:0]  acc_max     = 8'd0;
  logic [7:0]  acc_min     = 8'd255;
  int unsigned acc_sum     = 0;
  int unsigned acc_cnt     = 0;
  logic        acc_dropped = 1'b0;
  logic [7:0]  slice_buf [MAX_SLICES];

  in_req_t  slice_queue[$];
  out_res_t expected_proj[$];

  int mismatches   = 0;
  int quiet_cycles = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  bit hold_req     = 1'b0;
  bit steady       = 1'b0;

  slab_intensity_projection_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] median_of(int unsigned n);
    logic [7:0] srt [MAX_SLICES];
    logic [7:0] v;
    int         j;
    int         a;
    int         b;
    for (int i = 0; i < n; i++) srt[i] = slice_buf[i];
    for (int i = 1; i < n; i++) begin
      v = srt[i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    if (n % 2 == 0) begin
      a = srt[n/2 - 1];
      b = srt[n/2];
      return 8'((a + b) / 2);
    end
    return srt[n/2];
  endfunction

  function automatic void project_sample(in_req_t r);
    out_res_t res;
    if (acc_cnt < MAX_SLICES) begin
      slice_buf[acc_cnt] = r.sample;
      acc_cnt++;
      acc_sum += r.sample;
      if (r.sample > acc_max) acc_max = r.sample;
      if (r.sample < acc_min) acc_min = r.sample;
    end else begin
      acc_dropped = 1'b1;
    end
    if (r.last) begin
      case (proj_mode)
        MODE_MAX:  res.projected = acc_max;
        MODE_MIN:  res.projected = acc_min;
        MODE_MEAN: res.projected = 8'(acc_sum / acc_cnt);
        default:   res.projected = median_of(acc_cnt);
      endcase
      res.overflow = acc_dropped;
      expected_proj.push_back(res);
      acc_max     = 8'd0;
      acc_min     = 8'd255;
      acc_sum     = 0;
      acc_cnt     = 0;
      acc_dropped = 1'b0;
    end
  endfunction

  function automatic void report_mismatch(string msg);
    $display("%0t ns mismatch: %s", $realtime, msg);
    mismatches++;
  endfunction

  function automatic void check_result(out_res_t got);
    out_res_t want;
    if (expected_proj.size() == 0) begin
      report_mismatch($sformatf("result %02h/%0b with no request pending",
                                got.projected, got.overflow));
      return;
    end
    want = expected_proj.pop_front();
    if (got.projected !== want.projected)
      report_mismatch($sformatf("projected %02h, expected %02h",
                                got.projected, want.projected));
    if (got.overflow !== want.overflow)
      report_mismatch($sformatf("overflow %0b, expected %0b",
                                got.overflow, want.overflow));
  endfunction

  // one position: every value a slice request, last marked on the final one
  function automatic void queue_position(int vals[$]);
    in_req_t r;
    foreach (vals[i]) begin
      r.sample = 8'(vals[i]);
      r.last   = (i == vals.size() - 1);
      slice_queue.push_back(r);
    end
  endfunction

  task automatic write_mode(mode_t m);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    proj_mode  = m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic drain();
    while (slice_queue.size() != 0 || in_valid || expected_proj.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) project_sample(in_data);
      if (!in_valid || !in_stall) begin
        if (slice_queue.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data  <= slice_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int    vals[$];
    int    budget;
    int    len;
    int    lo;
    int    hi;
    mode_t m;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, single slice, even and odd medians, mean floor
    for (int k = 0; k < 4; k++) begin
      write_mode(mode_t'(k));
      @(negedge clk);
      vals = {255, 0};
      queue_position(vals);
      vals = {7};
      queue_position(vals);
      if (mode_t'(k) == MODE_MEAN) begin
        vals = {1, 2};
        queue_position(vals);
      end
      if (mode_t'(k) == MODE_MEDIAN) begin
        vals = {200, 3, 100};
        queue_position(vals);
        vals = {10, 13, 200, 1};
        queue_position(vals);
      end
      drain();
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0, 8:    m = MODE_MEDIAN;
        1:       m = MODE_MAX;
        2, 9:    m = MODE_MEAN;
        3:       m = MODE_MIN;
        default: m = mode_t'($urandom_range(0, 3));
      endcase
      write_mode(m);
      @(negedge clk);
      steady   <= (ph == 2);
      hold_req <= (ph == 5);
      budget = PHASE_BUDGET;
      while (budget > 0) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
        case ($urandom_range(0, 3))
          0: begin
            lo = $urandom_range(0, 252);
            hi = lo + 3;
          end
          1: begin
            lo = 0;
            hi = 0;
          end
          default: begin
            lo = 0;
            hi = 255;
          end
        endcase
        vals = {};
        for (int i = 0; i < len; i++) begin
          // extremes-only positions pick 0 or 255 per slice
          if (hi == 0) vals.push_back($urandom_range(0, 1) ? 255 : 0);
          else vals.push_back($urandom_range(lo, hi));
        end
        queue_position(vals);
        budget -= len;
      end
      // over-length positions: marked request dropped, and a few extra dropped
      if (ph == 8 || ph == 9) begin
        len = (ph == 8) ? MAX_SLICES + 1 : MAX_SLICES + 3;
        lo  = (ph == 8) ? 0 : 200;
        vals = {};
        for (int i = 0; i < len; i++) vals.push_back($urandom_range(lo, 255));
        queue_position(vals);
      end
      drain();
      steady <= 1'b0;
    end

    drain();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
